>>> rtl/core/gasp_pkg.sv
// Shared types and constants for the glyph atlas shelf packer.
// No dependencies; imported by gasp_place and glyph_atlas_shelf_packer.

package gasp_pkg;

  localparam int unsigned GLYPH_LIMIT = 1024;

  localparam int unsigned GlyphW  = 10;
  localparam int unsigned AtlasW  = 12;
  localparam int unsigned PlaceW  = 11;
  localparam int unsigned CountW  = 11;

  localparam logic [AtlasW-1:0] ATLAS_RESET = 12'd1024;

  typedef enum logic [1:0] {
    STATUS_PLACED = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    CFG_ATLAS_WIDTH  = 1'b0,
    CFG_ATLAS_HEIGHT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [AtlasW-1:0] width;
    logic [AtlasW-1:0] height;
  } atlas_cfg_t;

  typedef struct packed {
    status_e           status;
    logic [PlaceW-1:0] place_x;
    logic [PlaceW-1:0] place_y;
    logic [AtlasW-1:0] region_x;
    logic [AtlasW-1:0] region_y;
    logic [AtlasW-1:0] region_w;
    logic [AtlasW-1:0] region_h;
  } result_t;

endpackage

>>> rtl/core/glyph_atlas_shelf_packer.sv
// Top level of the glyph atlas shelf packer: input register, atlas size
// registers, output register. Depends on gasp_pkg and gasp_place.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one glyph size word.
//   Output channel (out_valid_o / out_ready_i) returns one result word per
//   input word: status, placement and the dirty region after that glyph.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes atlas width
//   (index 0) or atlas height (index 1); it is always ready. Write it only
//   while no word is in flight.
// Throughput: one word per cycle while out_ready_i is high; the placement
//   decision is one pass of adds and compares between the input register
//   and the output register.
// Stall: while out_ready_i is low the result word holds and one more input
//   word is taken into the input register; then in_ready_o drops.
// Reset: the pen goes to column 1, row 1, the shelf, glyph count and dirty
//   region clear, and the atlas size returns to 1024 x 1024.

module glyph_atlas_shelf_packer #(
  parameter int unsigned GlyphLimit = gasp_pkg::GLYPH_LIMIT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gasp_pkg::GlyphW-1:0]  glyph_width_i,
  input  logic [gasp_pkg::GlyphW-1:0]  glyph_height_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [gasp_pkg::PlaceW-1:0]  place_x_o,
  output logic [gasp_pkg::PlaceW-1:0]  place_y_o,
  output logic [gasp_pkg::AtlasW-1:0]  region_x_o,
  output logic [gasp_pkg::AtlasW-1:0]  region_y_o,
  output logic [gasp_pkg::AtlasW-1:0]  region_w_o,
  output logic [gasp_pkg::AtlasW-1:0]  region_h_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [gasp_pkg::AtlasW-1:0]  cfg_data_i
);
  import gasp_pkg::*;

  logic              in_valid_q;
  logic [GlyphW-1:0] glyph_w_q, glyph_h_q;
  logic              out_valid_q;
  result_t           result_q, result;
  atlas_cfg_t        atlas_q;
  logic              advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      glyph_w_q <= glyph_width_i;
      glyph_h_q <= glyph_height_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_q.width  <= ATLAS_RESET;
      atlas_q.height <= ATLAS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ATLAS_WIDTH:  atlas_q.width  <= cfg_data_i;
        CFG_ATLAS_HEIGHT: atlas_q.height <= cfg_data_i;
        default:          atlas_q        <= atlas_q;
      endcase
    end
  end

  gasp_place #(
    .GlyphLimit (GlyphLimit)
  ) u_place (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .glyph_width_i  (glyph_w_q),
    .glyph_height_i (glyph_h_q),
    .atlas_i        (atlas_q),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = result_q.status;
  assign place_x_o   = result_q.place_x;
  assign place_y_o   = result_q.place_y;
  assign region_x_o  = result_q.region_x;
  assign region_y_o  = result_q.region_y;
  assign region_w_o  = result_q.region_w;
  assign region_h_o  = result_q.region_h;

endmodule

>>> rtl/core/gasp_place.sv
// Placement stage: pen, shelf, glyph count and dirty region state plus the
// single-pass placement decision. Depends on gasp_pkg.

module gasp_place #(
  parameter int unsigned GlyphLimit = gasp_pkg::GLYPH_LIMIT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [gasp_pkg::GlyphW-1:0]  glyph_width_i,
  input  logic [gasp_pkg::GlyphW-1:0]  glyph_height_i,
  input  gasp_pkg::atlas_cfg_t         atlas_i,
  output gasp_pkg::result_t            result_o
);
  import gasp_pkg::*;

  logic [AtlasW-1:0] pen_col_q, pen_col_d;
  logic [AtlasW-1:0] pen_row_q, pen_row_d;
  logic [PlaceW-1:0] shelf_q, shelf_d;
  logic [CountW-1:0] total_q, total_d;
  logic [AtlasW-1:0] dirty_x_q, dirty_x_d;
  logic [AtlasW-1:0] dirty_y_q, dirty_y_d;
  logic [AtlasW-1:0] dirty_w_q, dirty_w_d;
  logic [AtlasW-1:0] dirty_h_q, dirty_h_d;

  logic              limit_hit, empty, oversize, wrap, row_full;
  logic [AtlasW:0]   ow_sum, oh_sum, wrap_sum, row_sum, bottom_sum;
  logic [AtlasW:0]   dirty_r, dirty_b, r_max, b_max;
  logic [AtlasW-1:0] col, left, top, right, bottom, x_min, y_min;
  logic [PlaceW-1:0] shelf_sel;

  assign limit_hit = total_q >= CountW'(GlyphLimit);
  assign empty     = (glyph_width_i == '0) || (glyph_height_i == '0);

  assign ow_sum   = (AtlasW+1)'(glyph_width_i) + (AtlasW+1)'(2);
  assign oh_sum   = (AtlasW+1)'(glyph_height_i) + (AtlasW+1)'(2);
  assign oversize = (ow_sum > {1'b0, atlas_i.width}) || (oh_sum > {1'b0, atlas_i.height});

  assign wrap_sum = (AtlasW+1)'(pen_col_q) + (AtlasW+1)'(glyph_width_i) + (AtlasW+1)'(1);
  assign wrap     = wrap_sum > {1'b0, atlas_i.width};

  assign col       = wrap ? AtlasW'(1) : pen_col_q;
  assign row_sum   = wrap ? (AtlasW+1)'(pen_row_q) + (AtlasW+1)'(shelf_q) + (AtlasW+1)'(1)
                          : (AtlasW+1)'(pen_row_q);
  assign shelf_sel = wrap ? '0 : shelf_q;

  assign bottom_sum = row_sum + (AtlasW+1)'(glyph_height_i) + (AtlasW+1)'(1);
  assign row_full   = bottom_sum > {1'b0, atlas_i.height};

  assign left   = col - AtlasW'(1);
  assign top    = row_sum[AtlasW-1:0] - AtlasW'(1);
  assign right  = col + AtlasW'(glyph_width_i) + AtlasW'(1);
  assign bottom = bottom_sum[AtlasW-1:0];

  assign x_min   = (dirty_x_q < left) ? dirty_x_q : left;
  assign y_min   = (dirty_y_q < top) ? dirty_y_q : top;
  assign dirty_r = (AtlasW+1)'(dirty_x_q) + (AtlasW+1)'(dirty_w_q);
  assign dirty_b = (AtlasW+1)'(dirty_y_q) + (AtlasW+1)'(dirty_h_q);
  assign r_max   = (dirty_r > {1'b0, right}) ? dirty_r : {1'b0, right};
  assign b_max   = (dirty_b > {1'b0, bottom}) ? dirty_b : {1'b0, bottom};

  always_comb begin
    pen_col_d = pen_col_q;
    pen_row_d = pen_row_q;
    shelf_d   = shelf_q;
    total_d   = total_q;
    dirty_x_d = dirty_x_q;
    dirty_y_d = dirty_y_q;
    dirty_w_d = dirty_w_q;
    dirty_h_d = dirty_h_q;
    result_o.status  = STATUS_FULL;
    result_o.place_x = '0;
    result_o.place_y = '0;
    priority if (limit_hit) begin
      result_o.status = STATUS_FULL;
    end else if (empty) begin
      total_d         = total_q + CountW'(1);
      result_o.status = STATUS_EMPTY;
    end else if (oversize || row_full) begin
      result_o.status = STATUS_FULL;
    end else begin
      result_o.status  = STATUS_PLACED;
      result_o.place_x = col[PlaceW-1:0];
      result_o.place_y = row_sum[PlaceW-1:0];
      if (dirty_w_q == '0) begin
        dirty_x_d = left;
        dirty_y_d = top;
        dirty_w_d = right - left;
        dirty_h_d = bottom - top;
      end else begin
        dirty_x_d = x_min;
        dirty_y_d = y_min;
        dirty_w_d = AtlasW'(r_max - (AtlasW+1)'(x_min));
        dirty_h_d = AtlasW'(b_max - (AtlasW+1)'(y_min));
      end
      pen_col_d = right;
      pen_row_d = row_sum[AtlasW-1:0];
      shelf_d   = (shelf_sel > PlaceW'(glyph_height_i)) ? shelf_sel : PlaceW'(glyph_height_i);
      total_d   = total_q + CountW'(1);
    end
    result_o.region_x = dirty_x_d;
    result_o.region_y = dirty_y_d;
    result_o.region_w = dirty_w_d;
    result_o.region_h = dirty_h_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_col_q <= AtlasW'(1);
      pen_row_q <= AtlasW'(1);
      shelf_q   <= '0;
      total_q   <= '0;
      dirty_x_q <= '0;
      dirty_y_q <= '0;
      dirty_w_q <= '0;
      dirty_h_q <= '0;
    end else if (step_i) begin
      pen_col_q <= pen_col_d;
      pen_row_q <= pen_row_d;
      shelf_q   <= shelf_d;
      total_q   <= total_d;
      dirty_x_q <= dirty_x_d;
      dirty_y_q <= dirty_y_d;
      dirty_w_q <= dirty_w_d;
      dirty_h_q <= dirty_h_d;
    end
  end

endmodule

>>> tb/sv/gasp_placement_checker.sv
`timescale 1ns / 1ps
// Placement checker for the glyph atlas shelf packer: tracks atlas size writes,
// predicts the result word of every accepted glyph and compares it on arrival.
// Depends on gasp_pkg for widths, status codes and register indexes.

module gasp_placement_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [gasp_pkg::GlyphW-1:0] glyph_width_i,
  input  logic [gasp_pkg::GlyphW-1:0] glyph_height_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [1:0]                  status_i,
  input  logic [gasp_pkg::PlaceW-1:0] place_x_i,
  input  logic [gasp_pkg::PlaceW-1:0] place_y_i,
  input  logic [gasp_pkg::AtlasW-1:0] region_x_i,
  input  logic [gasp_pkg::AtlasW-1:0] region_y_i,
  input  logic [gasp_pkg::AtlasW-1:0] region_w_i,
  input  logic [gasp_pkg::AtlasW-1:0] region_h_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic                        cfg_index_i,
  input  logic [gasp_pkg::AtlasW-1:0] cfg_data_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 results_due_o
);
  import gasp_pkg::*;

  localparam int unsigned PrintCap = 200;

  logic [AtlasW-1:0] atlas_w_q;
  logic [AtlasW-1:0] atlas_h_q;
  logic [AtlasW-1:0] pen_col_q;
  logic [AtlasW-1:0] pen_row_q;
  logic [PlaceW-1:0] shelf_h_q;
  logic [CountW-1:0] glyph_count_q;
  logic [AtlasW-1:0] dirty_x_q;
  logic [AtlasW-1:0] dirty_y_q;
  logic [AtlasW-1:0] dirty_w_q;
  logic [AtlasW-1:0] dirty_h_q;

  result_t placements_due[$];
  result_t due;

  task automatic report_mismatch(input string msg);
    if (mismatches_o < PrintCap) begin
      $display("%0t placement check: %s", $realtime, msg);
    end
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [AtlasW-1:0] got,
                             input logic [AtlasW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic place_glyph(input logic [GlyphW-1:0] w, input logic [GlyphW-1:0] h,
                             output result_t r);
    int unsigned col, row, shelf, left, top, right, bottom;
    int unsigned lo_x, lo_y, hi_x, hi_y;
    r = '0;
    r.status = STATUS_FULL;
    if (glyph_count_q < GLYPH_LIMIT && (w == 0 || h == 0)) begin
      glyph_count_q = glyph_count_q + 1'b1;
      r.status = STATUS_EMPTY;
    end else if (glyph_count_q < GLYPH_LIMIT && w + 2 <= atlas_w_q && h + 2 <= atlas_h_q) begin
      col = pen_col_q;
      row = pen_row_q;
      shelf = shelf_h_q;
      // wrap to a fresh shelf below the tallest glyph plus one padding row
      if (col + w + 1 > atlas_w_q) begin
        col = 1;
        row = row + shelf + 1;
        shelf = 0;
      end
      if (row + h + 1 <= atlas_h_q) begin
        left = col - 1;
        top = row - 1;
        right = col + w + 1;
        bottom = row + h + 1;
        if (dirty_w_q == 0) begin
          lo_x = left;
          lo_y = top;
          hi_x = right;
          hi_y = bottom;
        end else begin
          lo_x = (dirty_x_q < left) ? dirty_x_q : left;
          lo_y = (dirty_y_q < top) ? dirty_y_q : top;
          hi_x = dirty_x_q + dirty_w_q;
          hi_y = dirty_y_q + dirty_h_q;
          if (right > hi_x) hi_x = right;
          if (bottom > hi_y) hi_y = bottom;
        end
        dirty_x_q = AtlasW'(lo_x);
        dirty_y_q = AtlasW'(lo_y);
        dirty_w_q = AtlasW'(hi_x - lo_x);
        dirty_h_q = AtlasW'(hi_y - lo_y);
        pen_col_q = AtlasW'(right);
        pen_row_q = AtlasW'(row);
        shelf_h_q = PlaceW'((shelf > h) ? shelf : h);
        glyph_count_q = glyph_count_q + 1'b1;
        r.status = STATUS_PLACED;
        r.place_x = PlaceW'(col);
        r.place_y = PlaceW'(row);
      end
    end
    r.region_x = dirty_x_q;
    r.region_y = dirty_y_q;
    r.region_w = dirty_w_q;
    r.region_h = dirty_h_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q = ATLAS_RESET;
      atlas_h_q = ATLAS_RESET;
      pen_col_q = 1;
      pen_row_q = 1;
      shelf_h_q = '0;
      glyph_count_q = '0;
      dirty_x_q = '0;
      dirty_y_q = '0;
      dirty_w_q = '0;
      dirty_h_q = '0;
      placements_due.delete();
      mismatches_o = 0;
      results_due_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (placements_due.size() == 0) begin
          report_mismatch("result word with no glyph pending");
        end else begin
          due = placements_due.pop_front();
          check_field("status", status_i, due.status);
          check_field("place_x", place_x_i, due.place_x);
          check_field("place_y", place_y_i, due.place_y);
          check_field("region_x", region_x_i, due.region_x);
          check_field("region_y", region_y_i, due.region_y);
          check_field("region_w", region_w_i, due.region_w);
          check_field("region_h", region_h_i, due.region_h);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_ATLAS_WIDTH: begin
            atlas_w_q = cfg_data_i;
          end
          CFG_ATLAS_HEIGHT: begin
            atlas_h_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        place_glyph(glyph_width_i, glyph_height_i, due);
        placements_due.push_back(due);
      end
      results_due_o = placements_due.size();
    end
  end

endmodule

>>> tb/sv/tb_glyph_atlas_shelf_packer.sv
`timescale 1ns / 1ps
// Top of the glyph atlas shelf packer testbench: clock, reset, glyph stimulus,
// atlas size writes and the verdict. Depends on gasp_pkg, the packer and
// gasp_placement_checker, which predicts and compares every result word.

module tb_glyph_atlas_shelf_packer;
  import gasp_pkg::*;

  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned SettleCycles  = 8;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [GlyphW-1:0] glyph_w = '0;
  logic [GlyphW-1:0] glyph_h = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [PlaceW-1:0] place_x;
  logic [PlaceW-1:0] place_y;
  logic [AtlasW-1:0] region_x;
  logic [AtlasW-1:0] region_y;
  logic [AtlasW-1:0] region_w;
  logic [AtlasW-1:0] region_h;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_index_e        cfg_index = CFG_ATLAS_WIDTH;
  logic [AtlasW-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned results_due;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 63;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  glyph_atlas_shelf_packer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .glyph_width_i  (glyph_w),
    .glyph_height_i (glyph_h),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .place_x_o      (place_x),
    .place_y_o      (place_y),
    .region_x_o     (region_x),
    .region_y_o     (region_y),
    .region_w_o     (region_w),
    .region_h_o     (region_h),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  gasp_placement_checker u_placement_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .glyph_width_i  (glyph_w),
    .glyph_height_i (glyph_h),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .place_x_i      (place_x),
    .place_y_i      (place_y),
    .region_x_i     (region_x),
    .region_y_i     (region_y),
    .region_w_i     (region_w),
    .region_h_i     (region_h),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .results_due_o  (results_due)
  );

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HoldOffCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic offer_glyph(input logic [GlyphW-1:0] w, input logic [GlyphW-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    glyph_w <= w;
    glyph_h <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and hold until every result word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic set_atlas(input logic [AtlasW-1:0] w, input logic [AtlasW-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ATLAS_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_ATLAS_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pack_random(input logic [AtlasW-1:0] atlas_w, input logic [AtlasW-1:0] atlas_h,
                             input int unsigned count, input int unsigned max_w,
                             input int unsigned max_h, input bit hold_off);
    int unsigned roll;
    logic [GlyphW-1:0] w, h;
    wait_drained();
    set_atlas(atlas_w, atlas_h);
    if (hold_off) begin
      hold_requests <= hold_requests + 1;
    end
    repeat (count) begin
      roll = $urandom_range(99);
      w = GlyphW'($urandom_range(1023));
      h = GlyphW'($urandom_range(1023));
      if (roll < 4) begin
        if ($urandom_range(1)) w = '0;
        else h = '0;
      end else if (roll >= 8) begin
        w = GlyphW'($urandom_range(max_w, 1));
        h = GlyphW'($urandom_range(max_h, 1));
      end
      offer_glyph(w, h);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset atlas of 1024 x 1024
    offer_glyph(0, 0);
    offer_glyph(0, 1023);
    offer_glyph(1023, 0);
    offer_glyph(1, 1);
    offer_glyph(1023, 1);
    offer_glyph(1, 1023);
    offer_glyph(1022, 1);
    offer_glyph(1022, 1022);
    offer_glyph(10, 10);
    wait_drained();
    set_atlas(4095, 4095);
    offer_glyph(1023, 1023);
    offer_glyph(1023, 1023);
    offer_glyph(1023, 1023);
    offer_glyph(1010, 1);
    wait_drained();
    set_atlas(0, 0);
    offer_glyph(1, 1);
    offer_glyph(0, 7);
    wait_drained();
    set_atlas(1, 1);
    offer_glyph(1, 1);
    wait_drained();
    set_atlas(2048, 4095);
    offer_glyph(5, 5);

    pack_random(2048, 4095, 350, 40, 30, 1'b0);
    pack_random(160, 4095, 300, 300, 8, 1'b0);

    send_idle_pct = 63;
    recv_idle_pct = 25;
    pack_random(3, 4095, 100, 2, 3, 1'b0);
    pack_random(4095, 4095, 250, 1023, 16, 1'b0);
    pack_random(4095, 2100, 200, 64, 64, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    pack_random(4095, 4095, 500, 24, 10, 1'b1);

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> glyph_atlas_shelf_packer.f
rtl/core/gasp_pkg.sv
rtl/core/gasp_place.sv
rtl/core/glyph_atlas_shelf_packer.sv
tb/sv/gasp_placement_checker.sv
tb/sv/tb_glyph_atlas_shelf_packer.sv
